/* rtl/char_lcd_i2c_expander_writer_core_defines.svh */
// assertion macros shared by the lcd writer rtl
`ifndef CHAR_LCD_I2C_EXPANDER_WRITER_CORE_DEFINES_SVH
`define CHAR_LCD_I2C_EXPANDER_WRITER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CLIE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcd writer: implication check failed");

// next-cycle implication, sampled on clk, off during rst
`define CLIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcd writer: next-cycle check failed");

`endif

/* rtl/clie_pkg.sv */
// types, constants and helpers for the lcd expander writer
`default_nettype none
package clie_pkg;

  typedef enum logic [3:0] {
    CMD_INIT   = 4'd0,
    CMD_INSTR  = 4'd1,
    CMD_DATA   = 4'd2,
    CMD_HEX8   = 4'd3,
    CMD_HEX16  = 4'd4,
    CMD_DEC8   = 4'd5,
    CMD_DEC16  = 4'd6,
    CMD_BL_ON  = 4'd7,
    CMD_BL_OFF = 4'd8
  } clie_cmd_t;

  // how the back end expands one queued entry
  typedef enum logic [1:0] {
    KIND_RAW    = 2'd0,
    KIND_NIBBLE = 2'd1,
    KIND_CHAR   = 2'd2
  } clie_kind_t;

  typedef struct packed {
    clie_kind_t  kind;
    logic [7:0]  data;
    logic        rs;
    logic        last;
  } clie_entry_t;

  localparam int IDX_W = 3;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] idx;
  } clie_front_status_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PIN_BL = 8'h08;
  localparam logic [7:0] PIN_EN = 8'h04;
  localparam logic [7:0] PIN_RS = 8'h01;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_A    = 8'd65;

  localparam int ADDR_W = 7;
  localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd39;

  localparam int DIV_W = 14;
  localparam logic [DIV_W-1:0] DEC_DIVISORS [0:4] = '{
    14'd10000, 14'd1000, 14'd100, 14'd10, 14'd1
  };

  localparam logic [3:0] INIT_NIBBLES [0:3] = '{4'h3, 4'h3, 4'h3, 4'h2};
  localparam logic [7:0] INIT_INSTRS  [0:3] = '{8'h28, 8'h0C, 8'h06, 8'h01};

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = ASCII_ZERO + {4'h0, n};
    end else begin
      r = ASCII_A + {4'h0, n} - 8'd10;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/char_lcd_i2c_expander_writer_core.sv */
// top level of the character lcd writer over an i2c port expander
//
// requests arrive on the s_ stream: s_tuser carries the command, s_tdata the
// value. each request turns into the expander bytes of a 4-bit lcd write,
// which leave on the m_ stream one item per cycle while m_tready is high, with the expander address;
// m_tlast marks the final byte of a request. commands 9 to 15 are taken and
// produce nothing. cfg_valid/cfg_data write the expander address, always ready.
// byte counts: init 36, instruction or data 6, hex8 12, hex16 24, dec8 18,
// dec16 30, backlight 1. the back end's byte sequencer emits one byte per
// cycle while m_tready is high. a new request is taken as soon as the front
// end has queued the last entry of the previous one. the first byte passes
// through the front end's request register, the queue and the output register.
// rst clears the queue, output valid and sets the address to 39.
// when m_tready is low the output register holds and the four-entry queue
// fills, after which the front end and then s_tready stall.
`default_nettype none
`include "char_lcd_i2c_expander_writer_core_defines.svh"
module char_lcd_i2c_expander_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [3:0]  s_tuser,   // [3:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] bus_address, [14:7] bus_byte, [15] zero
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import clie_pkg::*;

  logic [ADDR_W-1:0]  addr_reg;
  logic               fr_push_valid;
  logic               fr_push_ready;
  clie_entry_t        fr_entry;
  clie_front_status_t fr_status;
  logic               q_valid;
  logic               bk_ready;
  clie_entry_t        q_entry;
  logic [ADDR_W-1:0]  out_address;
  logic [7:0]         out_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_reg <= ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      addr_reg <= cfg_data;
    end
  end

  clie_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (s_tuser),
    .in_value   (s_tdata),
    .push_valid (fr_push_valid),
    .push_ready (fr_push_ready),
    .push_entry (fr_entry),
    .status     (fr_status)
  );

  clie_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_push_valid),
    .push_ready (fr_push_ready),
    .push_entry (fr_entry),
    .pop_valid  (q_valid),
    .pop_ready  (bk_ready),
    .pop_entry  (q_entry)
  );

  clie_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (bk_ready),
    .q_entry     (q_entry),
    .address     (addr_reg),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_address (out_address),
    .out_byte    (out_byte),
    .out_last    (m_tlast)
  );

  assign m_tdata = {1'b0, out_byte, out_address};

  // a known command always starts the front end at its first entry
  `CLIE_ASSERT_NEXT(a_known_starts, s_tvalid && s_tready && (s_tuser <= 4'(CMD_BL_OFF)), fr_status.busy && (fr_status.idx == '0))
  // an unknown command leaves the front end idle
  `CLIE_ASSERT_NEXT(a_unknown_idle, s_tvalid && s_tready && (s_tuser > 4'(CMD_BL_OFF)), !fr_status.busy)
  // the back end only pops a queue that holds an entry
  `CLIE_ASSERT_IMPLY(a_pop_nonempty, bk_ready, q_valid)

endmodule
`default_nettype wire

/* rtl/clie_front.sv */
// front end: takes requests and breaks them into nibble, char and raw entries
`default_nettype none
module clie_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [3:0]                   in_cmd,
  input  logic [15:0]                  in_value,
  output logic                         push_valid,
  input  logic                         push_ready,
  output clie_pkg::clie_entry_t        push_entry,
  output clie_pkg::clie_front_status_t status
);
  import clie_pkg::*;

  logic             busy;
  clie_cmd_t        cmd_r;
  logic [15:0]      value_r;
  logic [IDX_W-1:0] idx;

  logic             accept;
  logic             fire;
  logic             known;
  logic [IDX_W-1:0] div_idx;
  logic [DIV_W-1:0] div;
  logic [17:0]      rem_work;
  logic [17:0]      trial;
  logic [3:0]       digit;
  logic [1:0]       hsel;
  logic [3:0]       hnib;

  assign known      = (in_cmd <= 4'(CMD_BL_OFF));
  assign push_valid = busy;
  assign fire       = push_valid && push_ready;
  assign in_ready   = !busy || (fire && push_entry.last);
  assign accept     = in_valid && in_ready;
  assign status     = '{busy: busy, idx: idx};

  // dec8 starts two places down the divisor table
  assign div_idx = (cmd_r == CMD_DEC8) ? idx + IDX_W'(2) : idx;
  assign div     = DEC_DIVISORS[div_idx];

  // one decimal digit by restoring compare-subtract, four quotient bits
  always_comb begin
    rem_work = {2'b00, value_r};
    digit    = '0;
    trial    = '0;
    for (int b = 3; b >= 0; b--) begin
      trial = {4'b0000, div} << b;
      if (rem_work >= trial) begin
        rem_work = rem_work - trial;
        digit[b] = 1'b1;
      end
    end
  end

  assign hsel = (cmd_r == CMD_HEX16) ? idx[1:0] : idx[1:0] + 2'd2;

  always_comb begin
    unique case (hsel)
      2'd0: hnib = value_r[15:12];
      2'd1: hnib = value_r[11:8];
      2'd2: hnib = value_r[7:4];
      2'd3: hnib = value_r[3:0];
      default: hnib = value_r[3:0];
    endcase
  end

  always_comb begin
    push_entry = '{kind: KIND_CHAR, data: 8'h00, rs: 1'b0, last: 1'b0};
    unique case (cmd_r)
      CMD_INIT: begin
        if (idx[2]) begin
          push_entry.data = INIT_INSTRS[idx[1:0]];
        end else begin
          push_entry.kind = KIND_NIBBLE;
          push_entry.data = {4'h0, INIT_NIBBLES[idx[1:0]]};
        end
        push_entry.last = (idx == IDX_W'(7));
      end
      CMD_INSTR: begin
        push_entry.data = value_r[7:0];
        push_entry.last = 1'b1;
      end
      CMD_DATA: begin
        push_entry.data = value_r[7:0];
        push_entry.rs   = 1'b1;
        push_entry.last = 1'b1;
      end
      CMD_HEX8: begin
        push_entry.data = hex_ascii(hnib);
        push_entry.rs   = 1'b1;
        push_entry.last = (idx == IDX_W'(1));
      end
      CMD_HEX16: begin
        push_entry.data = hex_ascii(hnib);
        push_entry.rs   = 1'b1;
        push_entry.last = (idx == IDX_W'(3));
      end
      CMD_DEC8: begin
        push_entry.data = ASCII_ZERO + {4'h0, digit};
        push_entry.rs   = 1'b1;
        push_entry.last = (idx == IDX_W'(2));
      end
      CMD_DEC16: begin
        push_entry.data = ASCII_ZERO + {4'h0, digit};
        push_entry.rs   = 1'b1;
        push_entry.last = (idx == IDX_W'(4));
      end
      CMD_BL_ON: begin
        push_entry.kind = KIND_RAW;
        push_entry.data = PIN_BL;
        push_entry.last = 1'b1;
      end
      CMD_BL_OFF: begin
        push_entry.kind = KIND_RAW;
        push_entry.last = 1'b1;
      end
      default: begin
        push_entry.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (accept) begin
      busy <= known;
      idx  <= '0;
    end else if (fire) begin
      busy <= !push_entry.last;
      idx  <= idx + IDX_W'(1);
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= clie_cmd_t'(in_cmd);
      value_r <= (in_cmd == 4'(CMD_DEC8)) ? {8'h00, in_value[7:0]} : in_value;
    end else if (fire && (cmd_r == CMD_DEC8 || cmd_r == CMD_DEC16)) begin
      value_r <= rem_work[15:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/clie_queue.sv */
// short entry queue between front and back end
`default_nettype none
module clie_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  clie_pkg::clie_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output clie_pkg::clie_entry_t pop_entry
);
  import clie_pkg::*;

  clie_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* rtl/clie_back.sv */
// back end: entries to expander bytes, one per cycle unless stalled, in the output reg
`default_nettype none
module clie_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  clie_pkg::clie_entry_t q_entry,
  input  logic [clie_pkg::ADDR_W-1:0] address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [clie_pkg::ADDR_W-1:0] out_address,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import clie_pkg::*;

  logic [2:0] step;
  logic [2:0] final_step;
  logic       load;
  logic       pop;
  logic       en;
  logic [3:0] nib;
  logic [7:0] byte_next;

  always_comb begin
    unique case (q_entry.kind)
      KIND_RAW:    final_step = 3'd0;
      KIND_NIBBLE: final_step = 3'd2;
      KIND_CHAR:   final_step = 3'd5;
      default:     final_step = 3'd0;
    endcase
  end

  // enable is high on the middle byte of each nibble
  assign en  = (step == 3'd1) || (step == 3'd4);
  assign nib = (q_entry.kind == KIND_CHAR && step < 3'd3) ? q_entry.data[7:4]
                                                          : q_entry.data[3:0];

  always_comb begin
    if (q_entry.kind == KIND_RAW) begin
      byte_next = q_entry.data;
    end else begin
      byte_next = {nib, 4'h0} | PIN_BL | (en ? PIN_EN : 8'h00)
                | (q_entry.rs ? PIN_RS : 8'h00);
    end
  end

  assign load    = q_valid && (!out_valid || out_ready);
  assign pop     = load && (step == final_step);
  assign q_ready = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step <= pop ? 3'd0 : step + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_address <= address;
      out_byte    <= byte_next;
      out_last    <= q_entry.last && (step == final_step);
    end
  end

endmodule
`default_nettype wire
